[rtl/core/stuck_signal_variance_detector_unit_defines.svh]
// Assertion macros shared by the checker of the stuck-signal detector.
`ifndef STUCK_SIGNAL_VARIANCE_DETECTOR_UNIT_DEFINES_SVH
`define STUCK_SIGNAL_VARIANCE_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSVD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ssvd_pkg.sv]
// Types and fixed constants of the stuck-signal variance detector.
package ssvd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int THR_W      = 16;
    localparam int SQ1_W      = 31;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [THR_W-1:0]           threshold_t;
    typedef logic [SQ1_W-1:0]           square_t;

    localparam threshold_t THR_RESET = 16'd16;

    typedef struct packed {
        logic stuck;
        logic window_full;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } ssvd_ctl_t;

endpackage

[rtl/core/ssvd_if.sv]
// Channel interfaces of the stuck-signal variance detector.
interface ssvd_sample_if;
    import ssvd_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface ssvd_result_if;
    import ssvd_pkg::*;
    logic valid;
    logic ready;
    logic stuck;
    logic window_full;
    modport source (output valid, output stuck, output window_full, input ready);
    modport sink (input valid, input stuck, input window_full, output ready);
endinterface

interface ssvd_cfg_if;
    import ssvd_pkg::*;
    logic       valid;
    logic       ready;
    threshold_t variance_threshold;
    modport source (output valid, output variance_threshold, input ready);
    modport sink (input valid, input variance_threshold, output ready);
endinterface

[rtl/core/stuck_signal_variance_detector_unit.sv]
// A sample passes the stage-1 registers, sums, compare stage and result queue.
// One sample per cycle while ready is high; the window memory takes one read at
// acceptance and one write of the new sample the next cycle, on separate ports.
// Up to eight results may be in flight or queued before samples are held off.
// Reset clears the pointer, fill count, sums and queue; the threshold returns to 16.
// The window memory needs no clearing: read data is used only after it is written.
module stuck_signal_variance_detector_unit #(
    parameter int WINDOW_DEPTH = 64
) (
    input logic           clk,
    input logic           rst_n,
    ssvd_sample_if.sink   samples,
    ssvd_result_if.source results,
    ssvd_cfg_if.sink      cfg
);
    import ssvd_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int SQ_W  = SQ1_W + AW;

    threshold_t              thr_reg;
    logic [CNT_W-1:0]        credit_reg, credit_next;
    logic                    in_fire;
    logic                    out_fire;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    ssvd_ctl_t               ctl;
    logic                    push;
    result_t                 push_data;
    logic                    out_valid;
    result_t                 out_data;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (credit_reg < CNT_W'(FIFO_DEPTH));
    assign in_fire       = samples.valid && samples.ready;
    assign out_fire      = results.valid && results.ready;

    always_comb
    begin
        credit_next = credit_reg + CNT_W'(in_fire) - CNT_W'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            credit_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                thr_reg <= cfg.variance_threshold;
            end
            credit_reg <= credit_next;
        end
    end

    ssvd_accum #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_sample (samples.sample),
        .sum       (sum),
        .sumsq     (sumsq),
        .ctl       (ctl)
    );

    ssvd_test #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sum       (sum),
        .sumsq     (sumsq),
        .threshold (thr_reg),
        .push      (push),
        .push_data (push_data)
    );

    ssvd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (out_fire),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign results.valid       = out_valid;
    assign results.stuck       = out_data.stuck;
    assign results.window_full = out_data.window_full;

endmodule

[rtl/core/ssvd_window_ram.sv]
// Sample window memory: one write port, one registered read port.
module ssvd_window_ram #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
    input  ssvd_pkg::sample_t               wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
    output ssvd_pkg::sample_t               rd_data
);
    import ssvd_pkg::*;

    sample_t window_reg [WINDOW_DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= window_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/ssvd_accum.sv]
// Window pointer, fill count and read-modify-write of the running sums.
module ssvd_accum #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_fire,
    input  ssvd_pkg::sample_t                           in_sample,
    output logic signed [16+$clog2(WINDOW_DEPTH)-1:0]   sum,
    output logic [31+$clog2(WINDOW_DEPTH)-1:0]          sumsq,
    output ssvd_pkg::ssvd_ctl_t                         ctl
);
    import ssvd_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int FW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int SQ_W  = SQ1_W + AW;
    localparam logic [FW-1:0] FULL_CNT = FW'(WINDOW_DEPTH);
    localparam logic [FW-1:0] LAST_CNT = FW'(WINDOW_DEPTH - 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);

    logic [AW-1:0]           wp_reg, wp_next;
    logic [FW-1:0]           fill_reg, fill_next;
    logic                    s1_valid_reg;
    logic                    s1_full_before_reg;
    logic                    s1_full_after_reg;
    logic [AW-1:0]           s1_addr_reg;
    sample_t                 s1_x_reg;
    square_t                 s1_xsq_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sumsq_reg, sumsq_next;
    ssvd_ctl_t               s2_ctl_reg;

    logic signed [31:0]      x_prod;
    logic signed [31:0]      old_prod;
    sample_t                 rd_data;
    sample_t                 old_sample;

    ssvd_window_ram #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_x_reg),
        .rd_en   (in_fire),
        .rd_addr (wp_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wp_next   = (wp_reg == LAST_PTR) ? '0 : wp_reg + AW'(1);
        fill_next = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + FW'(1);
        x_prod    = in_sample * in_sample;
    end

    // The oldest entry leaves the sums only once the window was already full,
    // so the data read for an entry is used only after it has been written.
    always_comb
    begin
        old_sample = s1_full_before_reg ? rd_data : '0;
        old_prod   = old_sample * old_sample;
        sum_next   = sum_reg + SUM_W'(s1_x_reg) - SUM_W'(old_sample);
        sumsq_next = sumsq_reg + SQ_W'(s1_xsq_reg) - SQ_W'(old_prod[SQ1_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg             <= '0;
            fill_reg           <= '0;
            s1_valid_reg       <= 1'b0;
            s1_full_before_reg <= 1'b0;
            s1_full_after_reg  <= 1'b0;
            sum_reg            <= '0;
            sumsq_reg          <= '0;
            s2_ctl_reg         <= '0;
        end
        else
        begin
            s1_valid_reg     <= in_fire;
            s2_ctl_reg.valid <= s1_valid_reg;
            s2_ctl_reg.full  <= s1_full_after_reg;
            if (in_fire)
            begin
                wp_reg             <= wp_next;
                fill_reg           <= fill_next;
                s1_full_before_reg <= (fill_reg == FULL_CNT);
                s1_full_after_reg  <= (fill_reg == FULL_CNT) || (fill_reg == LAST_CNT);
            end
            if (s1_valid_reg)
            begin
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= wp_reg;
            s1_x_reg    <= in_sample;
            s1_xsq_reg  <= x_prod[SQ1_W-1:0];
        end
    end

    assign sum   = sum_reg;
    assign sumsq = sumsq_reg;
    assign ctl   = s2_ctl_reg;

endmodule

[rtl/core/ssvd_test.sv]
// Two-stage variance test: products, then the spread-against-limit compare.
module ssvd_test #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  ssvd_pkg::ssvd_ctl_t                         ctl,
    input  logic signed [16+$clog2(WINDOW_DEPTH)-1:0]   sum,
    input  logic [31+$clog2(WINDOW_DEPTH)-1:0]          sumsq,
    input  ssvd_pkg::threshold_t                        threshold,
    output logic                                        push,
    output ssvd_pkg::result_t                           push_data
);
    import ssvd_pkg::*;

    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int NW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + AW;
    localparam int SQ_W  = SQ1_W + AW;
    localparam int CMP_W = SQ_W + NW;
    localparam int LIM_W = THR_W + 2 * NW;
    localparam logic [NW-1:0]   N_C  = NW'(WINDOW_DEPTH);
    localparam logic [2*NW-1:0] NN_C = (2 * NW)'(WINDOW_DEPTH * WINDOW_DEPTH);

    logic signed [2*SUM_W-1:0] sum_sq;
    logic [CMP_W-1:0]          nsq_next;
    logic [LIM_W-1:0]          lim_next;

    ssvd_ctl_t                 s3_ctl_reg;
    logic [2*SUM_W-1:0]        sum_sq_reg;
    logic [CMP_W-1:0]          nsq_reg;
    logic [LIM_W-1:0]          lim_reg;
    logic [CMP_W-1:0]          spread;

    always_comb
    begin
        sum_sq   = (2 * SUM_W)'(sum) * (2 * SUM_W)'(sum);
        nsq_next = CMP_W'(sumsq) * CMP_W'(N_C);
        lim_next = LIM_W'(threshold) * LIM_W'(NN_C);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else
        begin
            s3_ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            sum_sq_reg <= $unsigned(sum_sq);
            nsq_reg    <= nsq_next;
            lim_reg    <= lim_next;
        end
    end

    // N*sumsq never falls below sum^2, so the spread is a plain unsigned value.
    always_comb
    begin
        spread                = nsq_reg - CMP_W'(sum_sq_reg);
        push                  = s3_ctl_reg.valid;
        push_data.window_full = s3_ctl_reg.full;
        push_data.stuck       = s3_ctl_reg.full && (spread < CMP_W'(lim_reg));
    end

endmodule

[rtl/core/ssvd_result_fifo.sv]
// Result queue that decouples the compare pipeline from the output beat.
module ssvd_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssvd_pkg::result_t push_data,
    input  logic              pop,
    output logic              out_valid,
    output ssvd_pkg::result_t out_data
);
    import ssvd_pkg::*;

    result_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_reg[rd_ptr_reg];

endmodule

[rtl/core/ssvd_checker.sv]
// Port-level checker of the stuck-signal detector and its bind to the top level.
`include "stuck_signal_variance_detector_unit_defines.svh"

module ssvd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_stuck,
    input logic out_window_full
);
    logic [7:0] outstanding_reg;
    logic       seen_full_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            seen_full_reg   <= 1'b0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 8'(in_fire) - 8'(out_fire);
            if (out_fire && out_window_full)
            begin
                seen_full_reg <= 1'b1;
            end
        end
    end

    // A frozen signal can only be reported on a full window.
    `SSVD_ASSERT_NOW(a_stuck_needs_full, clk, rst_n, out_valid && out_stuck, out_window_full, "stuck raised before the window is full")

    // Every result beat belongs to a sample that was taken earlier.
    `SSVD_ASSERT_NOW(a_no_extra_result, clk, rst_n, out_valid, outstanding_reg != 8'd0, "result shown with no sample outstanding")

    // Once full, the window stays full until reset.
    `SSVD_ASSERT_NOW(a_full_sticks, clk, rst_n, out_fire && seen_full_reg, out_window_full, "window_full dropped after it was reported")

    // A stalled result holds its beat.
    `SSVD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_stuck) && $stable(out_window_full), "stalled result changed")

endmodule

bind stuck_signal_variance_detector_unit ssvd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_stuck       (results.stuck),
    .out_window_full (results.window_full)
);

[dv/stuck_signal_variance_detector_unit_test.sv]
// Testbench for the stuck-signal variance detector: directed table, then random windows.
module stuck_signal_variance_detector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ssvd_pkg::*;

    localparam int WINDOW_DEPTH = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 80;
    localparam int PHASE_ITEMS  = 36;

    typedef enum {ROW_SAMPLES, ROW_ALTERNATE, ROW_THRESHOLD} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int          value;
        int unsigned run_len;
        bit          pinned;
        bit          exp_stuck;
        bit          exp_full;
    } stim_row_t;

    // Only the last beat of a pinned row carries a typed result.
    stim_row_t directed_rows [19] = '{
        '{ROW_SAMPLES,   -32768,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,    32767,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,        0,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,       -1,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,        1,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,    21845,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,   -21846,  1, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,    32767, 56, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLES,    32767,  1, 1'b1, 1'b0, 1'b1},
        '{ROW_SAMPLES,    32767, 64, 1'b1, 1'b1, 1'b1},
        '{ROW_SAMPLES,   -32768, 64, 1'b1, 1'b1, 1'b1},
        '{ROW_THRESHOLD,      0,  0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLES,   -32768,  1, 1'b1, 1'b0, 1'b1},
        '{ROW_THRESHOLD,  65535,  0, 1'b0, 1'b0, 1'b0},
        '{ROW_ALTERNATE,    255, 64, 1'b1, 1'b1, 1'b1},
        '{ROW_ALTERNATE,    256, 64, 1'b1, 1'b0, 1'b1},
        '{ROW_THRESHOLD,     16,  0, 1'b0, 1'b0, 1'b0},
        '{ROW_ALTERNATE,      4, 64, 1'b1, 1'b0, 1'b1},
        '{ROW_ALTERNATE,      3, 64, 1'b1, 1'b1, 1'b1}
    };

    bit   clk;
    logic rst_n;

    ssvd_sample_if sample_ch ();
    ssvd_result_if result_ch ();
    ssvd_cfg_if    cfg_ch ();

    stuck_signal_variance_detector_unit #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(sample_ch),
        .results(result_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the window and its sums.
    sample_t     window_mem [WINDOW_DEPTH];
    int unsigned wr_ptr           = 0;
    int unsigned fill_count       = 0;
    longint      running_sum      = 0;
    longint      running_sum_sq   = 0;
    threshold_t  threshold_shadow = THR_RESET;

    result_t expected_flags [$];
    bit      pin_active = 1'b0;
    result_t pin_flags;
    bit      hold_request = 1'b0;
    int      burst_left = 0;
    int      fail_count = 0;
    int      cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t window_variance_update(sample_t x);
        result_t r;
        longint  oldest;
        longint  spread;
        longint  limit;
        if (fill_count == WINDOW_DEPTH)
        begin
            oldest = window_mem[wr_ptr];
            running_sum    -= oldest;
            running_sum_sq -= oldest * oldest;
        end
        window_mem[wr_ptr] = x;
        running_sum    += longint'(x);
        running_sum_sq += longint'(x) * longint'(x);
        wr_ptr = (wr_ptr == WINDOW_DEPTH - 1) ? 0 : wr_ptr + 1;
        if (fill_count < WINDOW_DEPTH)
            fill_count++;
        r.window_full = (fill_count == WINDOW_DEPTH);
        r.stuck = 1'b0;
        if (r.window_full)
        begin
            spread = longint'(WINDOW_DEPTH) * running_sum_sq - running_sum * running_sum;
            limit  = longint'(threshold_shadow) * WINDOW_DEPTH * WINDOW_DEPTH;
            r.stuck = (spread < limit);
        end
        return r;
    endfunction

    // Prediction on every accepted sample beat, checking on every accepted result beat.
    always @(posedge clk)
    begin
        result_t predicted;
        result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                threshold_shadow = cfg_ch.variance_threshold;
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted = window_variance_update(sample_ch.sample);
                expected_flags.push_back(pin_active ? pin_flags : predicted);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_flags.size() == 0)
                begin
                    $display("%0t: unexpected result beat stuck=%0b window_full=%0b",
                             $time, result_ch.stuck, result_ch.window_full);
                    fail_count++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (result_ch.stuck !== want.stuck)
                    begin
                        $display("%0t: stuck expected %0b actual %0b",
                                 $time, want.stuck, result_ch.stuck);
                        fail_count++;
                    end
                    if (result_ch.window_full !== want.window_full)
                    begin
                        $display("%0t: window_full expected %0b actual %0b",
                                 $time, want.window_full, result_ch.window_full);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: segments of steady, random and patterned stalls, plus one long hold-off.
    initial
    begin : result_sink
        int seg_left;
        int mode;
        int tick;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        tick      = 0;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 60);
                mode = $urandom_range(0, 2);
            end
            seg_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (mode == 0)
                result_ch.ready <= 1'b1;
            else if (mode == 1)
                result_ch.ready <= 1'($urandom_range(0, 1));
            else
                result_ch.ready <= (tick % 3 == 0);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_sample(input sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (expected_flags.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input threshold_t thr);
        cfg_ch.valid              <= 1'b1;
        cfg_ch.variance_threshold <= thr;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         v;
        int         base;
        int         amp;
        int         mode;
        int         seg_len;
        int         sent;
        threshold_t thr;
        rst_n                     = 1'b0;
        sample_ch.valid           = 1'b0;
        sample_ch.sample          = '0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.variance_threshold = THR_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_THRESHOLD)
            begin
                sample_ch.valid <= 1'b0;
                wait_drained();
                write_threshold(threshold_t'(directed_rows[i].value));
            end
            else
            begin
                for (int k = 0; k < directed_rows[i].run_len; k++)
                begin
                    v = directed_rows[i].value;
                    if (directed_rows[i].kind == ROW_ALTERNATE && (k % 2) == 1)
                        v = -v;
                    pin_active = directed_rows[i].pinned && (k == directed_rows[i].run_len - 1);
                    pin_flags.stuck       = directed_rows[i].exp_stuck;
                    pin_flags.window_full = directed_rows[i].exp_full;
                    send_sample(sample_t'(v));
                end
            end
        end
        pin_active = 1'b0;

        for (int phase = 0; phase < 7; phase++)
        begin
            sample_ch.valid <= 1'b0;
            wait_drained();
            case ($urandom_range(0, 3))
                0: thr = '0;
                1: thr = '1;
                2: thr = threshold_t'($urandom_range(1, 64));
                default: thr = threshold_t'($urandom_range(0, 65535));
            endcase
            write_threshold(thr);
            // Starve the result side while samples keep coming, so the queue fills.
            if (phase == 2)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                seg_len = $urandom_range(20, 90);
                mode    = $urandom_range(0, 19);
                base    = int'($urandom_range(0, 65535)) - 32768;
                amp     = int'($urandom_range(0, 1 << $urandom_range(0, 9)));
                for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++)
                begin
                    if (mode < 3)
                        v = int'($urandom_range(0, 65535)) - 32768;
                    else if (mode < 5)
                    begin
                        case ($urandom_range(0, 3))
                            0: v = -32768;
                            1: v = 32767;
                            2: v = 0;
                            default: v = -1;
                        endcase
                    end
                    else
                    begin
                        // Near-constant signal, so full windows sit around the threshold.
                        v = base + int'($urandom_range(0, 2 * amp)) - amp;
                        if (v > 32767)
                            v = 32767;
                        if (v < -32768)
                            v = -32768;
                    end
                    send_sample(sample_t'(v));
                    sent++;
                end
            end
        end

        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
